// ===== hw/rtl/dnt_pkg.sv =====
// Shared types and constants for the decimal number token checker.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package dnt_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_EXP    = 8'h65;  // 'e'
    localparam logic [CHAR_W-1:0] CH_SUFFIX = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;  // '-'

    localparam logic [3:0] RADIX = 4'd10;

    // One character item.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } in_item_t;

    // Token flags carried from character to character.
    typedef struct packed {
        logic at_first;
        logic int_ok;
        logic int_digit_seen;
        logic float_ok;
        logic seen_digit;
        logic seen_point;
        logic seen_exponent;
        logic expect_exp_lead;
        logic suffix_seen;
        logic negative;
    } scan_flags_t;

    localparam scan_flags_t FLAGS_RESET = '{
        at_first:        1'b1,
        int_ok:          1'b1,
        int_digit_seen:  1'b0,
        float_ok:        1'b1,
        seen_digit:      1'b0,
        seen_point:      1'b0,
        seen_exponent:   1'b0,
        expect_exp_lead: 1'b0,
        suffix_seen:     1'b0,
        negative:        1'b0
    };

    // One verdict item.
    typedef struct packed {
        logic                      is_integer;
        logic                      is_float;
        logic signed [VALUE_W-1:0] int_value;
    } result_t;

endpackage

// ===== hw/rtl/dnt_in_reg.sv =====
// Input register for the character channel; one item deep, refills in the
// cycle it drains. Depends on dnt_pkg.
`timescale 1ns / 1ps

module dnt_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dnt_pkg::in_item_t s_item,
    input  logic              take,      // downstream consumes the held item
    output logic              hold_valid,
    output dnt_pkg::in_item_t hold_item
);

    logic              valid_reg;
    logic              valid_next;
    dnt_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    // a take only ever drains a held item
    a_take_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> valid_reg)
        else $error("dnt_in_reg: take without a held item");

endmodule

// ===== hw/rtl/dnt_scan.sv =====
// Token scanner: flag update and mod 2^64 accumulation for one character per
// cycle while step is high, verdict formed on the final character. Depends on dnt_pkg.
`timescale 1ns / 1ps

module dnt_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dnt_pkg::in_item_t   item,
    output dnt_pkg::result_t    result
);

    dnt_pkg::scan_flags_t           flags_reg;
    dnt_pkg::scan_flags_t           flags_next;
    dnt_pkg::scan_flags_t           upd;
    logic [dnt_pkg::VALUE_W-1:0]    acc_reg;     // +value
    logic [dnt_pkg::VALUE_W-1:0]    acc_next;
    logic [dnt_pkg::VALUE_W-1:0]    nacc_reg;    // -value, kept in parallel
    logic [dnt_pkg::VALUE_W-1:0]    nacc_next;
    logic [dnt_pkg::VALUE_W-1:0]    acc_upd;
    logic [dnt_pkg::VALUE_W-1:0]    nacc_upd;
    logic [dnt_pkg::VALUE_W-1:0]    digit_val;
    logic [dnt_pkg::CHAR_W-1:0]     c;
    logic                           digit;
    logic                           sign;
    logic                           is_int;

    assign c     = item.char_code;
    assign digit = c inside {[dnt_pkg::CH_ZERO:dnt_pkg::CH_NINE]};
    assign sign  = (c == dnt_pkg::CH_PLUS) || (c == dnt_pkg::CH_MINUS);
    assign digit_val = {{(dnt_pkg::VALUE_W-dnt_pkg::CHAR_W){1'b0}}, c - dnt_pkg::CH_ZERO};

    always_comb begin
        upd = flags_reg;

        // integer path
        if (flags_reg.at_first) begin
            if (digit) begin
                upd.int_digit_seen = 1'b1;
            end else if (sign) begin
                upd.negative = (c == dnt_pkg::CH_MINUS);
            end else begin
                upd.int_ok = 1'b0;
            end
        end else if (digit) begin
            upd.int_digit_seen = 1'b1;
        end else begin
            upd.int_ok = 1'b0;
        end

        // float path
        if (flags_reg.at_first) begin
            if (digit) begin
                upd.seen_digit = 1'b1;
            end else if (c == dnt_pkg::CH_POINT) begin
                upd.seen_point = 1'b1;
            end else if (!sign) begin
                upd.float_ok = 1'b0;
            end
        end else if (flags_reg.expect_exp_lead) begin
            upd.expect_exp_lead = 1'b0;
            if (!digit && !sign) begin
                upd.float_ok = 1'b0;
            end
        end else if (flags_reg.suffix_seen) begin
            upd.float_ok = 1'b0;
        end else if (digit) begin
            upd.seen_digit = 1'b1;
        end else if (c == dnt_pkg::CH_POINT && !flags_reg.seen_point
                     && !flags_reg.seen_exponent) begin
            upd.seen_point = 1'b1;
        end else if (c == dnt_pkg::CH_EXP && !flags_reg.seen_exponent) begin
            upd.seen_exponent   = 1'b1;
            upd.expect_exp_lead = 1'b1;
        end else if (c == dnt_pkg::CH_SUFFIX && item.last_char) begin
            upd.suffix_seen = 1'b1;
        end else begin
            upd.float_ok = 1'b0;
        end

        upd.at_first = 1'b0;

        // times ten as shift-and-add
        acc_upd  = acc_reg;
        nacc_upd = nacc_reg;
        if (digit) begin
            acc_upd  = (acc_reg << 3) + (acc_reg << 1) + digit_val;
            nacc_upd = (nacc_reg << 3) + (nacc_reg << 1) - digit_val;
        end

        flags_next = flags_reg;
        acc_next   = acc_reg;
        nacc_next  = nacc_reg;
        if (step) begin
            if (item.last_char) begin
                flags_next = dnt_pkg::FLAGS_RESET;
                acc_next   = '0;
                nacc_next  = '0;
            end else begin
                flags_next = upd;
                acc_next   = acc_upd;
                nacc_next  = nacc_upd;
            end
        end
    end

    assign is_int = upd.int_ok && upd.int_digit_seen;

    always_comb begin
        result.is_integer = is_int;
        result.is_float   = upd.float_ok && !upd.expect_exp_lead && upd.seen_digit
                            && (upd.seen_point || upd.seen_exponent);
        result.int_value  = '0;
        if (is_int) begin
            result.int_value = upd.negative ? nacc_upd : acc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= dnt_pkg::FLAGS_RESET;
            acc_reg   <= '0;
            nacc_reg  <= '0;
        end else begin
            flags_reg <= flags_next;
            acc_reg   <= acc_next;
            nacc_reg  <= nacc_next;
        end
    end

    // final character returns the scanner to a fresh token
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.last_char) |=> (flags_reg == dnt_pkg::FLAGS_RESET
                                      && acc_reg == '0 && nacc_reg == '0))
        else $error("dnt_scan: state not cleared after final character");

    // the two accumulators stay negatives of each other
    a_acc_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg + nacc_reg) == '0)
        else $error("dnt_scan: accumulator pair out of step");

endmodule

// ===== hw/rtl/decimal_number_token_check_top.sv =====
// Top level of the decimal number token checker: input register, scanner,
// result register. Depends on dnt_pkg, dnt_in_reg and dnt_scan.
`timescale 1ns / 1ps
// Path: a final character goes from the input register through the scanner into
//   the result register, and its verdict shows on m_*.
// Throughput: one character item per cycle unless a final character waits on a
//   held verdict; the times-ten add is combinational, so items run back to back.
// Reset: aresetn low at a clock edge empties both registers and returns the
//   scanner to the start of a token; no clearing pass is needed.
module decimal_number_token_check_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // character channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_char_code,
    input  logic                                 s_last_char,
    // verdict channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_is_integer,
    output logic                                 m_is_float,
    output logic signed [dnt_pkg::VALUE_W-1:0]   m_int_value
);

    dnt_pkg::in_item_t s_item;
    dnt_pkg::in_item_t hold_item;
    logic              hold_valid;
    logic              take;
    dnt_pkg::result_t  scan_result;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    dnt_pkg::result_t  out_reg;

    assign s_item.char_code = s_char_code;
    assign s_item.last_char = s_last_char;

    // Only a final character produces an item, so only it waits on the
    // result register; all other characters advance every cycle.
    assign take = hold_valid && (!hold_item.last_char || !out_valid_reg || m_ready);

    dnt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    dnt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (hold_item),
        .result  (scan_result)
    );

    wire load = take && hold_item.last_char;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= scan_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_is_integer = out_reg.is_integer;
    assign m_is_float   = out_reg.is_float;
    assign m_int_value  = out_reg.int_value;

    // a verdict is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !load)
        else $error("top: verdict overwritten before taken");

    // every final character consumed leaves a verdict behind
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> out_valid_reg)
        else $error("top: final character produced no verdict");

endmodule

// ===== verif/tb.sv =====
// Testbench for decimal_number_token_check_top: streams number tokens one character per item
// and checks every verdict against the typed-in one or a cycle-free scanner model in the bench.
// Depends on dnt_pkg and the RTL of the token checker only.
`timescale 1ns / 1ps

module tb;

    // Watchdog: cycles in a row with no handshake on either channel.
    localparam int IDLE_LIMIT   = 4000;
    // Stop the random part after about this many characters.
    localparam int RANDOM_CHARS = 1700;
    // Wait after the final verdict, as a margin before the end.
    localparam int DRAIN_CYCLES = 8;

    // Directed script: one character per row. Rows marked fixed carry the verdict typed in;
    // the others are left to the scanner model.
    typedef struct packed {
        logic [dnt_pkg::CHAR_W-1:0]  ch;
        logic                        last;
        logic                        fixed;
        logic                        w_int;
        logic                        w_flt;
        logic [dnt_pkg::VALUE_W-1:0] w_val;
    } script_row_t;

    localparam int SCRIPT_LEN = 24;
    localparam script_row_t TOKEN_SCRIPT [SCRIPT_LEN] = '{
        // "0": single digit, plain integer
        '{"0",                1'b1, 1'b1, 1'b1, 1'b0, 64'd0},
        // ".": point with no digit
        '{dnt_pkg::CH_POINT,  1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        // "1e+": exponent sign with no exponent digits is still a float
        '{"1",                1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_EXP,    1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_PLUS,   1'b1, 1'b1, 1'b0, 1'b1, 64'd0},
        // "1e": trailing exponent mark, lead character missing
        '{"1",                1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_EXP,    1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        // "-7": negative integer
        '{dnt_pkg::CH_MINUS,  1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{"7",                1'b1, 1'b1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9},
        // "-": lone sign
        '{dnt_pkg::CH_MINUS,  1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        // character code extremes as one-character tokens
        '{8'hFF,              1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        '{8'h00,              1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        // "+3.f": sign, point and suffix
        '{dnt_pkg::CH_PLUS,   1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{"3",                1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_POINT,  1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_SUFFIX, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0},
        // "1.e5": point then exponent
        '{"1",                1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_POINT,  1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_EXP,    1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{"5",                1'b1, 1'b0, 1'b0, 1'b0, 64'd0},
        // "5f": suffix without point or exponent
        '{"5",                1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_SUFFIX, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0},
        // "..": second point
        '{dnt_pkg::CH_POINT,  1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{dnt_pkg::CH_POINT,  1'b1, 1'b0, 1'b0, 1'b0, 64'd0}
    };

    // ---------------------------------------------------------------
    // Clock, reset and DUT. Every input has a known value from time 0.
    // ---------------------------------------------------------------
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [dnt_pkg::CHAR_W-1:0]  s_char_code = '0;
    logic                        s_last_char = 1'b0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic                        m_is_integer;
    logic                        m_is_float;
    logic signed [dnt_pkg::VALUE_W-1:0] m_int_value;

    always #1 aclk = ~aclk;

    decimal_number_token_check_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_last_char  (s_last_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_integer (m_is_integer),
        .m_is_float   (m_is_float),
        .m_int_value  (m_int_value)
    );

    // ---------------------------------------------------------------
    // Scanner model: the bench's own copy of the token flags and the
    // running value, advanced once per accepted character item.
    // ---------------------------------------------------------------
    typedef struct packed {
        bit first;      // next character opens a token
        bit int_good;   // still shaped like an integer
        bit int_dig;    // integer path has seen a digit
        bit flt_good;   // still shaped like a float literal
        bit dig;        // float path has seen a mantissa/exponent digit
        bit point;
        bit expo;
        bit exp_lead;   // character after 'e' still to come
        bit suffix;
        bit neg;
    } scan_state_t;

    localparam scan_state_t SCAN_IDLE = '{first: 1'b1, int_good: 1'b1, flt_good: 1'b1,
                                          default: 1'b0};

    scan_state_t                 scan_st  = SCAN_IDLE;
    logic [dnt_pkg::VALUE_W-1:0] scan_acc = '0;

    // Advances the model by one character. Returns 1 with the verdict in v on a
    // final character, and puts the model back at the start of a token.
    function automatic bit scan_char(input logic [dnt_pkg::CHAR_W-1:0] c, input logic last,
                                     output dnt_pkg::result_t v);
        bit digit;
        bit sign;
        digit = (c >= dnt_pkg::CH_ZERO) && (c <= dnt_pkg::CH_NINE);
        sign  = (c == dnt_pkg::CH_PLUS) || (c == dnt_pkg::CH_MINUS);
        v     = '0;

        // integer shape
        if (scan_st.first) begin
            if (digit)
                scan_st.int_dig = 1'b1;
            else if (sign)
                scan_st.neg = (c == dnt_pkg::CH_MINUS);
            else
                scan_st.int_good = 1'b0;
        end else if (digit) begin
            scan_st.int_dig = 1'b1;
        end else begin
            scan_st.int_good = 1'b0;
        end
        if (digit)
            scan_acc = scan_acc * dnt_pkg::VALUE_W'(dnt_pkg::RADIX)
                       + dnt_pkg::VALUE_W'(c - dnt_pkg::CH_ZERO);

        // float shape
        if (scan_st.first) begin
            if (digit)
                scan_st.dig = 1'b1;
            else if (c == dnt_pkg::CH_POINT)
                scan_st.point = 1'b1;
            else if (!sign)
                scan_st.flt_good = 1'b0;
        end else if (scan_st.exp_lead) begin
            // lead after 'e' does not count as a digit
            scan_st.exp_lead = 1'b0;
            if (!digit && !sign)
                scan_st.flt_good = 1'b0;
        end else if (scan_st.suffix) begin
            scan_st.flt_good = 1'b0;
        end else if (digit) begin
            scan_st.dig = 1'b1;
        end else if (c == dnt_pkg::CH_POINT && !scan_st.point && !scan_st.expo) begin
            scan_st.point = 1'b1;
        end else if (c == dnt_pkg::CH_EXP && !scan_st.expo) begin
            scan_st.expo     = 1'b1;
            scan_st.exp_lead = 1'b1;
        end else if (c == dnt_pkg::CH_SUFFIX && last) begin
            scan_st.suffix = 1'b1;
        end else begin
            scan_st.flt_good = 1'b0;
        end

        scan_st.first = 1'b0;
        if (!last)
            return 1'b0;

        v.is_integer = scan_st.int_good && scan_st.int_dig;
        v.is_float   = scan_st.flt_good && !scan_st.exp_lead && scan_st.dig &&
                       (scan_st.point || scan_st.expo);
        if (v.is_integer)
            v.int_value = scan_st.neg ? -scan_acc : scan_acc;
        scan_st  = SCAN_IDLE;
        scan_acc = '0;
        return 1'b1;
    endfunction

    // Verdicts owed by the DUT, oldest first.
    dnt_pkg::result_t pending_verdicts [$];
    int               n_mismatches = 0;

    task automatic note_mismatch(input string msg);
        n_mismatches++;
        if (n_mismatches <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of back-to-back characters with random gaps.
    // s_valid is lowered only when a gap follows, so it never drops and
    // rises within one time step.
    // ---------------------------------------------------------------
    int burst_left = 0;
    int chars_sent = 0;

    task automatic push_char(input logic [dnt_pkg::CHAR_W-1:0] ch, input logic last,
                             input bit fixed, input dnt_pkg::result_t fixed_verdict);
        dnt_pkg::result_t v;
        int               gap;
        s_valid     <= 1'b1;
        s_char_code <= ch;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted at this edge
        chars_sent++;
        if (scan_char(ch, last, v))
            pending_verdicts.push_back(fixed ? fixed_verdict : v);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // mostly short bursts; now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Pause the sender until every owed verdict has come back.
    task automatic drain_verdicts();
        if (pending_verdicts.size() != 0) begin
            s_valid <= 1'b0;
            while (pending_verdicts.size() != 0)
                @(posedge aclk);
        end
    endtask

    // ---------------------------------------------------------------
    // Random token builder. Most tokens are well-formed integers or floats
    // with random content; some are mutated, some are raw byte noise.
    // ---------------------------------------------------------------
    logic [dnt_pkg::CHAR_W-1:0] token_buf [$];

    function automatic logic [dnt_pkg::CHAR_W-1:0] rand_digit();
        return dnt_pkg::CH_ZERO + dnt_pkg::CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [dnt_pkg::CHAR_W-1:0] rand_special();
        case ($urandom_range(0, 6))
            0:       return dnt_pkg::CH_POINT;
            1:       return dnt_pkg::CH_EXP;
            2:       return dnt_pkg::CH_SUFFIX;
            3:       return dnt_pkg::CH_PLUS;
            4:       return dnt_pkg::CH_MINUS;
            5:       return rand_digit();
            default: return dnt_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_sign();
        case ($urandom_range(0, 3))
            0:       token_buf.push_back(dnt_pkg::CH_PLUS);
            1:       token_buf.push_back(dnt_pkg::CH_MINUS);
            default: ;
        endcase
    endtask

    task automatic build_int();
        int n;
        add_sign();
        // a few long ones wrap the 64-bit value
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
        repeat (n) token_buf.push_back(rand_digit());
    endtask

    task automatic build_float();
        int n;
        add_sign();
        repeat ($urandom_range(0, 4)) token_buf.push_back(rand_digit());
        if ($urandom_range(0, 3) != 0) begin
            token_buf.push_back(dnt_pkg::CH_POINT);
            repeat ($urandom_range(0, 4)) token_buf.push_back(rand_digit());
        end
        if ($urandom_range(0, 1) != 0) begin
            token_buf.push_back(dnt_pkg::CH_EXP);
            case ($urandom_range(0, 2))
                0:       token_buf.push_back(dnt_pkg::CH_PLUS);
                1:       token_buf.push_back(dnt_pkg::CH_MINUS);
                default: token_buf.push_back(rand_digit());
            endcase
            repeat ($urandom_range(0, 3)) token_buf.push_back(rand_digit());
        end
        if (token_buf.size() == 0)
            token_buf.push_back(rand_digit());
        if ($urandom_range(0, 4) == 0)
            token_buf.push_back(dnt_pkg::CH_SUFFIX);
    endtask

    task automatic build_token();
        int pick;
        int pos;
        token_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            build_int();
        end else if (pick < 75) begin
            build_float();
        end else if (pick < 90) begin
            // broken: a well-formed token with one fault
            if ($urandom_range(0, 1) != 0)
                build_int();
            else
                build_float();
            case ($urandom_range(0, 3))
                0: token_buf.push_back(dnt_pkg::CH_EXP);  // trailing exponent mark
                1: token_buf.insert($urandom_range(0, token_buf.size()), rand_special());
                default: begin
                    pos = $urandom_range(0, token_buf.size() - 1);
                    token_buf[pos] = rand_special();
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 6))
                token_buf.push_back(dnt_pkg::CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: m_ready follows a pattern of its own, switching between
    // always ready, coin flips, mostly stalled and a fixed duty cycle.
    // ---------------------------------------------------------------
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 300);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rx_tick % 8) < 5);
        endcase
    end

    // ---------------------------------------------------------------
    // Verdict checker and watchdog. Outputs are sampled at the edge,
    // before any register in the DUT updates.
    // ---------------------------------------------------------------
    int               idle_cycles = 0;
    dnt_pkg::result_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid === 1'b1 && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    note_mismatch($sformatf("verdict with none owed: int=%0b flt=%0b val=%0d",
                                            m_is_integer, m_is_float, m_int_value));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_is_integer !== want.is_integer)
                        note_mismatch($sformatf("is_integer exp %0b got %0b",
                                                want.is_integer, m_is_integer));
                    if (m_is_float !== want.is_float)
                        note_mismatch($sformatf("is_float exp %0b got %0b",
                                                want.is_float, m_is_float));
                    if (m_int_value !== want.int_value)
                        note_mismatch($sformatf("int_value exp %0d got %0d",
                                                want.int_value, m_int_value));
                end
            end

            if ((s_valid && s_ready) || (m_valid === 1'b1 && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: reset, directed script, random tokens, drain, verdict.
    // ---------------------------------------------------------------
    initial begin
        dnt_pkg::result_t fixed_verdict;
        script_row_t      row;
        int               n_tokens;

        // reset held low at the start, released once
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = TOKEN_SCRIPT[i];
            fixed_verdict.is_integer = row.w_int;
            fixed_verdict.is_float   = row.w_flt;
            fixed_verdict.int_value  = row.w_val;
            push_char(row.ch, row.last, row.fixed, fixed_verdict);
        end

        // all owed verdicts back before the random part
        drain_verdicts();

        // random tokens until the character budget is spent
        n_tokens = 0;
        fixed_verdict = '0;
        while (chars_sent < SCRIPT_LEN + RANDOM_CHARS) begin
            build_token();
            foreach (token_buf[k])
                push_char(token_buf[k], k == token_buf.size() - 1, 1'b0, fixed_verdict);
            n_tokens++;
            // every so often, let the result side empty completely
            if (n_tokens % 50 == 0)
                drain_verdicts();
        end
        s_valid <= 1'b0;

        // wait out the owed verdicts, then the pipeline depth and some margin
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== decimal_number_token_check_top.f =====
hw/rtl/dnt_pkg.sv
hw/rtl/dnt_in_reg.sv
hw/rtl/dnt_scan.sv
hw/rtl/decimal_number_token_check_top.sv
verif/tb.sv
